FILE: rtl/mhpq_pkg.sv
`timescale 1ns / 1ps

package mhpq_pkg;

    // Heap geometry
    localparam int CAPACITY    = 1024;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int CHILD_W     = CNT_W + 1;

    // Beat field widths
    localparam int KEY_W       = 32;
    localparam int OUT_CNT_W   = 11;

    // Operation codes
    localparam logic OP_PUSH   = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic start;       // latch the accepted beat, update the count
        logic fetch_last;  // read the last entry for a pop
        logic take_last;   // capture the last entry as the moving key
        logic place;       // write the moving key at the current hole
        logic issue;       // read parent or children of the hole
        logic eval;        // compare, then move one entry and advance the hole, or place the key
        logic out_load;    // load the result register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic op;          // latched operation
        logic rej;         // operation was ignored
        logic empty;       // no entries stored
        logic at_end;      // hole is at the root (push) or a leaf (pop)
        logic stop;        // sift ends on this compare
    } t_stat;

endpackage

FILE: rtl/mhpq_in_if.sv
`timescale 1ns / 1ps

interface mhpq_in_if;
    logic                               valid;
    logic                               ready;
    logic                               mode;
    logic signed [mhpq_pkg::KEY_W-1:0]  key_in;

    modport source (output valid, output mode, output key_in, input ready);
    modport sink   (input valid, input mode, input key_in, output ready);
endinterface

FILE: rtl/mhpq_out_if.sv
`timescale 1ns / 1ps

interface mhpq_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [mhpq_pkg::KEY_W-1:0]     min_key;
    logic                                  is_empty;
    logic        [mhpq_pkg::OUT_CNT_W-1:0] entry_count;
    logic                                  rejected;

    modport source (output valid, output min_key, output is_empty, output entry_count,
                    output rejected, input ready);
    modport sink   (input valid, input min_key, input is_empty, input entry_count,
                    input rejected, output ready);
endinterface

FILE: rtl/min_heap_priority_queue_core.sv
`timescale 1ns / 1ps

// Binary min-heap priority queue of signed 32-bit keys, up to 1024 entries.
// Input channel i_in: one beat per operation; mode 0 pushes key_in, mode 1
// pops the minimum (key_in ignored). Output channel o_out: exactly one beat
// per input beat, in order, carrying the minimum after the operation (zero
// when empty), the empty flag, the entry count and a rejected flag set for a
// push into a full heap or a pop from an empty one.
// A rejected operation, or a pop that empties the heap, skips the sift and
// goes straight to the result. A push sifts up from the new last slot and a
// pop sifts the last entry down from the root; a push into a heap of 1023
// entries can climb ten levels to the root.
// Each level reads the parent or both children from the heap memory, then
// compares and moves one entry.
// Operations are processed one at a time; the next beat is accepted in the
// cycle after the result is loaded.
// Reset (i_rst_n low, synchronous) empties the heap; memory contents are not
// cleared and need no clearing pass. A stalled receiver holds the result
// beat; the block then finishes at most one further operation and waits.
module min_heap_priority_queue_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mhpq_in_if.sink     i_in,
    mhpq_out_if.source  o_out
);

    mhpq_pkg::t_cmd  w_cmd;
    mhpq_pkg::t_stat w_stat;

    // Sequencer
    mhpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Heap storage and sift datapath
    mhpq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_mode        (i_in.mode),
        .i_key_in      (i_in.key_in),
        .o_min_key     (o_out.min_key),
        .o_is_empty    (o_out.is_empty),
        .o_entry_count (o_out.entry_count),
        .o_rejected    (o_out.rejected)
    );

endmodule

FILE: rtl/mhpq_ram.sv
`timescale 1ns / 1ps

module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

FILE: rtl/mhpq_ctrl.sv
`timescale 1ns / 1ps

module mhpq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  mhpq_pkg::t_stat i_stat,
    output mhpq_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUTE,
        S_LAST,
        S_READ,
        S_EVAL,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Command decode
    always_comb begin
        o_cmd            = '0;
        o_cmd.start      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.fetch_last = (r_state == S_ROUTE) && !i_stat.rej
                           && (i_stat.op == mhpq_pkg::OP_POP) && !i_stat.empty;
        o_cmd.take_last  = (r_state == S_LAST);
        o_cmd.place      = (r_state == S_READ) && i_stat.at_end;
        o_cmd.issue      = (r_state == S_READ) && !i_stat.at_end;
        o_cmd.eval       = (r_state == S_EVAL);
        o_cmd.out_load   = (r_state == S_OUT) && w_out_free;
    end

    // Sequencer and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // Set on load, cleared once the beat is taken
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_ROUTE;
                    end
                end
                S_ROUTE: begin
                    if (i_stat.rej) begin
                        r_state <= S_OUT;
                    end else if (i_stat.op == mhpq_pkg::OP_PUSH) begin
                        r_state <= S_READ;
                    end else if (i_stat.empty) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= i_stat.at_end ? S_OUT : S_EVAL;
                end
                S_EVAL: begin
                    r_state <= i_stat.stop ? S_OUT : S_READ;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    // A new beat is only taken with the sequencer at rest
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == S_ROUTE))
        else $error("start did not enter route");

    // A result is never loaded over one that is still pending
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten");
`endif

endmodule

FILE: rtl/mhpq_dp.sv
`timescale 1ns / 1ps

module mhpq_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  mhpq_pkg::t_cmd                        i_cmd,
    output mhpq_pkg::t_stat                       o_stat,
    input  logic                                  i_mode,
    input  logic signed [mhpq_pkg::KEY_W-1:0]     i_key_in,
    output logic signed [mhpq_pkg::KEY_W-1:0]     o_min_key,
    output logic                                  o_is_empty,
    output logic        [mhpq_pkg::OUT_CNT_W-1:0] o_entry_count,
    output logic                                  o_rejected
);

    // Working registers
    logic                                r_op;
    logic                                r_rej;
    logic signed [mhpq_pkg::KEY_W-1:0]   r_key;
    logic        [mhpq_pkg::ADDR_W-1:0]  r_pos;
    logic        [mhpq_pkg::CNT_W-1:0]   r_cnt;
    logic signed [mhpq_pkg::KEY_W-1:0]   r_min;

    // Result register
    logic signed [mhpq_pkg::KEY_W-1:0]     r_out_min;
    logic                                  r_out_empty;
    logic        [mhpq_pkg::OUT_CNT_W-1:0] r_out_cnt;
    logic                                  r_out_rej;

    // Index arithmetic
    logic [mhpq_pkg::CHILD_W-1:0] w_left;
    logic [mhpq_pkg::CHILD_W-1:0] w_right;
    logic [mhpq_pkg::CHILD_W-1:0] w_n;
    logic [mhpq_pkg::ADDR_W-1:0]  w_parent;
    logic [mhpq_pkg::ADDR_W-1:0]  w_pos_m1;
    logic                         w_full;
    logic                         w_empty;

    // Memory port signals
    logic                               w_we;
    logic [mhpq_pkg::ADDR_W-1:0]        w_raddr_a;
    logic signed [mhpq_pkg::KEY_W-1:0]  w_wdata;
    logic [mhpq_pkg::KEY_W-1:0]         w_rdata_a;
    logic [mhpq_pkg::KEY_W-1:0]         w_rdata_b;
    logic signed [mhpq_pkg::KEY_W-1:0]  w_val_a;
    logic signed [mhpq_pkg::KEY_W-1:0]  w_val_b;

    // Compare results
    logic                               w_has_right;
    logic                               w_pick_right;
    logic signed [mhpq_pkg::KEY_W-1:0]  w_pick_val;
    logic [mhpq_pkg::ADDR_W-1:0]        w_pick_idx;
    logic                               w_stop;
    logic [mhpq_pkg::ADDR_W-1:0]        w_next_pos;

    assign w_n      = mhpq_pkg::CHILD_W'(r_cnt);
    assign w_left   = (mhpq_pkg::CHILD_W'(r_pos) << 1) + mhpq_pkg::CHILD_W'(1);
    assign w_right  = w_left + mhpq_pkg::CHILD_W'(1);
    assign w_pos_m1 = r_pos - mhpq_pkg::ADDR_W'(1);
    assign w_parent = w_pos_m1 >> 1;
    assign w_full   = (r_cnt == mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY));
    assign w_empty  = (r_cnt == '0);

    assign w_val_a  = $signed(w_rdata_a);
    assign w_val_b  = $signed(w_rdata_b);

    // Child selection; a right child past the count is absent
    assign w_has_right  = (w_right < w_n);
    assign w_pick_right = w_has_right && (w_val_b < w_val_a);
    assign w_pick_val   = w_pick_right ? w_val_b : w_val_a;
    assign w_pick_idx   = w_pick_right ? w_right[mhpq_pkg::ADDR_W-1:0]
                                       : w_left[mhpq_pkg::ADDR_W-1:0];

    // Sift ends when the neighbor is in order; a push still climbs past an equal parent
    assign w_stop     = (r_op == mhpq_pkg::OP_POP) ? !(w_pick_val < r_key)
                                                   : (w_val_a < r_key);
    assign w_next_pos = (r_op == mhpq_pkg::OP_POP) ? w_pick_idx : w_parent;

    // Status to the controller
    always_comb begin
        o_stat.op     = r_op;
        o_stat.rej    = r_rej;
        o_stat.empty  = w_empty;
        o_stat.at_end = (r_op == mhpq_pkg::OP_POP) ? (w_left >= w_n) : (r_pos == '0);
        o_stat.stop   = w_stop;
    end

    // Memory access
    assign w_we      = i_cmd.place || i_cmd.eval;
    assign w_wdata   = (i_cmd.place || w_stop) ? r_key
                     : ((r_op == mhpq_pkg::OP_POP) ? w_pick_val : w_val_a);
    assign w_raddr_a = i_cmd.fetch_last ? r_cnt[mhpq_pkg::ADDR_W-1:0]
                     : ((r_op == mhpq_pkg::OP_POP) ? w_left[mhpq_pkg::ADDR_W-1:0]
                                                   : w_parent);

    mhpq_ram #(
        .WIDTH (mhpq_pkg::KEY_W),
        .DEPTH (mhpq_pkg::CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (r_pos),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_right[mhpq_pkg::ADDR_W-1:0]),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.start) begin
            if (i_mode == mhpq_pkg::OP_PUSH && !w_full) begin
                r_cnt <= r_cnt + mhpq_pkg::CNT_W'(1);
            end else if (i_mode == mhpq_pkg::OP_POP && !w_empty) begin
                r_cnt <= r_cnt - mhpq_pkg::CNT_W'(1);
            end
        end
    end

    // Operation, moving key, hole position and root copy
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op  <= i_mode;
            r_key <= i_key_in;
            r_rej <= (i_mode == mhpq_pkg::OP_PUSH) ? w_full : w_empty;
            r_pos <= (i_mode == mhpq_pkg::OP_PUSH) ? r_cnt[mhpq_pkg::ADDR_W-1:0] : '0;
        end
        if (i_cmd.take_last) begin
            r_key <= w_val_a;
        end
        if (i_cmd.eval && !w_stop) begin
            r_pos <= w_next_pos;
        end
        if (w_we && r_pos == '0) begin
            r_min <= w_wdata;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_min   <= w_empty ? '0 : r_min;
            r_out_empty <= w_empty;
            r_out_cnt   <= mhpq_pkg::OUT_CNT_W'(r_cnt);
            r_out_rej   <= r_rej;
        end
    end

    assign o_min_key     = r_out_min;
    assign o_is_empty    = r_out_empty;
    assign o_entry_count = r_out_cnt;
    assign o_rejected    = r_out_rej;

`ifndef ASSERT_OFF
    // Count stays within capacity
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY))
        else $error("count above capacity");

    // An accepted operation either changes the count or is rejected
    a_cnt_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |=> (r_rej || r_cnt != $past(r_cnt)))
        else $error("count unchanged on accepted operation");

    // Writes only land inside the live part of the heap
    a_wr_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (mhpq_pkg::CNT_W'(r_pos) < r_cnt))
        else $error("write beyond count");
`endif

endmodule
